// File: hw/rtl/blc_pkg.sv
package blc_pkg;

	// Code length: default and the largest supported value.
	localparam int CODE_LEN_DEF = 5;
	localparam int CODE_LEN_MAX = 7;

	// A job holds every output word caused by one input word.
	localparam int JOB_BYTES = CODE_LEN_MAX + 1;
	localparam int JOB_N_W   = $clog2(JOB_BYTES + 1);
	localparam int JOB_IDX_W = $clog2(JOB_BYTES);

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] CHAR_UP_A = 8'h41;
	localparam logic [7:0] CHAR_UP_B = 8'h42;
	localparam logic [7:0] CHAR_UP_Z = 8'h5A;
	localparam logic [7:0] CHAR_LO_A = 8'h61;
	localparam logic [7:0] CHAR_LO_B = 8'h62;
	localparam logic [7:0] CHAR_LO_Z = 8'h7A;

	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [JOB_N_W-1:0]        n;
		logic                      last;
	} job_t;

endpackage

// File: hw/rtl/baconian_letter_codec_top.sv
// Baconian codec on a byte stream. With decode_mode at 0 each ASCII letter
// becomes CODE_LEN words of A/B (or a/b for lowercase), most significant bit
// first, and every other byte passes through; with decode_mode at 1 a sliding
// window of CODE_LEN bytes turns letter groups of one case back into letters,
// and s_axis_tlast flushes the window. A write on the cfg channel sets the
// mode and drops any pending window bytes; write it only while the block is
// idle. The front end takes one input word per cycle while the job queue has
// room; the back end sends one output word per cycle, while m_axis_tready is
// high, from a single output register. An input word causes CODE_LEN words
// for an encoded letter, 1 for a passed byte, and 0 to CODE_LEN + 1 words in
// decode mode. The first word caused by an input word passes through the job
// queue and then the output register. m_axis_tlast marks the last word caused
// by one input word, and m_axis_tuser[0] marks the last word of the message.
module baconian_letter_codec_top #(
	parameter int CODE_LEN    = blc_pkg::CODE_LEN_DEF,
	parameter int QUEUE_DEPTH = blc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,       // decode_mode
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // in_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast,   // run_last
	output logic [0:0] m_axis_tuser    // [0] message_end
);
	import blc_pkg::*;

	job_t      front_job;
	job_t      head_job;
	logic      q_push;
	logic      q_full;
	logic      head_valid;
	logic      q_pop;
	logic      in_accept;
	logic      msg_end;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !q_full;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	blc_front #(
		.CODE_LEN(CODE_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_mode (cfg_data),
		.in_accept(in_accept),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.job      (front_job),
		.job_push (q_push)
	);

	blc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_job   (front_job),
		.push     (q_push),
		.full     (q_full),
		.rd_job   (head_job),
		.not_empty(head_valid),
		.pop      (q_pop)
	);

	blc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_job),
		.head_valid (head_valid),
		.pop        (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.run_last   (m_axis_tlast),
		.message_end(msg_end)
	);

	assign m_axis_tuser = msg_end;

endmodule

// File: hw/rtl/blc_front.sv
module blc_front #(
	parameter int CODE_LEN = 5
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_mode,
	input  logic         in_accept,
	input  logic [7:0]   in_byte,
	input  logic         in_last,
	output blc_pkg::job_t job,
	output logic         job_push
);
	import blc_pkg::*;

	localparam int CNT_W = $clog2(CODE_LEN + 1);

	typedef logic [CODE_LEN-1:0][7:0] win_t;

	logic             mode_q;
	logic [CNT_W-1:0] cnt_q;
	win_t             win_q;

	win_t             nwin;
	logic [CNT_W-1:0] ncnt;
	logic [CNT_W-1:0] ncnt_final;
	logic             old_ok;
	logic [7:0]       old_letter;
	logic             new_ok;
	logic [7:0]       new_letter;
	job_t             enc_job;
	job_t             dec_job;

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= CHAR_UP_A) && (c <= CHAR_UP_Z);
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= CHAR_LO_A) && (c <= CHAR_LO_Z);
	endfunction

	// A window decodes when all its words are letters of one case.
	function automatic logic test_win(input win_t w, output logic [7:0] letter);
		logic                all_letter;
		logic                any_up;
		logic                any_lo;
		logic [CODE_LEN-1:0] code;
		all_letter = 1'b1;
		any_up = 1'b0;
		any_lo = 1'b0;
		for (int i = 0; i < CODE_LEN; i++) begin
			all_letter = all_letter & (is_upper(w[i]) | is_lower(w[i]));
			any_up = any_up | is_upper(w[i]);
			any_lo = any_lo | is_lower(w[i]);
			code[CODE_LEN-1-i] = (w[i] == CHAR_UP_B) || (w[i] == CHAR_LO_B);
		end
		letter = 8'(code) + (any_up ? CHAR_UP_A : CHAR_LO_A);
		return all_letter && !(any_up && any_lo);
	endfunction

	// Encode job.
	always_comb begin
		logic                up;
		logic                lo;
		logic [7:0]          diff;
		logic [CODE_LEN-1:0] enc_code;
		logic [7:0]          zero;
		up = is_upper(in_byte);
		lo = is_lower(in_byte);
		diff = in_byte - (up ? CHAR_UP_A : CHAR_LO_A);
		enc_code = CODE_LEN'(diff[4:0]);
		zero = lo ? CHAR_LO_A : CHAR_UP_A;
		enc_job = '0;
		enc_job.last = in_last;
		if (up || lo) begin
			for (int k = 0; k < CODE_LEN; k++) begin
				enc_job.bytes[k] = zero + 8'(enc_code[CODE_LEN-1-k]);
			end
			enc_job.n = JOB_N_W'(CODE_LEN);
		end else begin
			enc_job.bytes[0] = in_byte;
			enc_job.n = JOB_N_W'(1);
		end
	end

	// Decode: window update, then the flush on the last word.
	always_comb begin
		logic             n0;
		logic [7:0]       first;
		logic [JOB_N_W-1:0] nflush;
		old_ok = test_win(win_q, old_letter);
		n0 = 1'b0;
		first = '0;
		nwin = win_q;
		if (cnt_q == CNT_W'(CODE_LEN)) begin
			n0 = 1'b1;
			if (old_ok) begin
				first = old_letter;
				nwin[0] = in_byte;
				ncnt = CNT_W'(1);
			end else begin
				first = win_q[0];
				for (int i = 0; i < CODE_LEN - 1; i++) begin
					nwin[i] = win_q[i+1];
				end
				nwin[CODE_LEN-1] = in_byte;
				ncnt = CNT_W'(CODE_LEN);
			end
		end else begin
			for (int i = 0; i < CODE_LEN; i++) begin
				if (cnt_q == CNT_W'(i)) begin
					nwin[i] = in_byte;
				end
			end
			ncnt = cnt_q + CNT_W'(1);
		end
		new_ok = test_win(nwin, new_letter) && (ncnt == CNT_W'(CODE_LEN));

		dec_job = '0;
		dec_job.last = in_last;
		dec_job.bytes[0] = first;
		nflush = '0;
		if (in_last) begin
			if (new_ok) begin
				dec_job.bytes[JOB_IDX_W'(n0)] = new_letter;
				nflush = JOB_N_W'(1);
			end else begin
				for (int j = 0; j < CODE_LEN; j++) begin
					if (CNT_W'(j) < ncnt) begin
						if (n0) begin
							dec_job.bytes[j+1] = nwin[j];
						end else begin
							dec_job.bytes[j] = nwin[j];
						end
					end
				end
				nflush = JOB_N_W'(ncnt);
			end
		end
		dec_job.n = JOB_N_W'(n0) + nflush;
		ncnt_final = in_last ? '0 : ncnt;
	end

	assign job = mode_q ? dec_job : enc_job;
	assign job_push = in_accept && (job.n != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cfg_we) begin
			mode_q <= cfg_mode;
			cnt_q  <= '0;
		end else if (in_accept && mode_q) begin
			cnt_q <= ncnt_final;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && mode_q) begin
			win_q <= nwin;
		end
	end

endmodule

// File: hw/rtl/blc_queue.sv
module blc_queue #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  blc_pkg::job_t        wr_job,
	input  logic                 push,
	output logic                 full,
	output blc_pkg::job_t        rd_job,
	output logic                 not_empty,
	input  logic                 pop
);
	import blc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_job    = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// File: hw/rtl/blc_back.sv
module blc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  blc_pkg::job_t head,
	input  logic          head_valid,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          run_last,
	output logic          message_end
);
	import blc_pkg::*;

	logic [JOB_IDX_W-1:0] idx_q;
	logic                 valid_q;
	logic [7:0]           byte_q;
	logic                 run_last_q;
	logic                 msg_end_q;

	logic load;
	logic last_word;

	// The output register loads when a job waits and it is empty or taken.
	assign load      = head_valid && (!valid_q || out_ready);
	assign last_word = (JOB_N_W'(idx_q) + JOB_N_W'(1)) == head.n;
	assign pop       = load && last_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last_word ? '0 : idx_q + JOB_IDX_W'(1);
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q     <= head.bytes[idx_q];
			run_last_q <= last_word;
			msg_end_q  <= last_word && head.last;
		end
	end

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign run_last    = run_last_q;
	assign message_end = msg_end_q;

endmodule

// File: hw/rtl/blc_checker.sv
module blc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic [0:0] m_axis_tuser
);

	// A stalled output word keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
		&& $stable(m_axis_tuser))
		else $error("stalled output word changed");

	// The end of a message is always the last word of its input word.
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("message end without run end");

	// Mode writes are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

	// Nothing leaves the block in the first cycle after reset.
	a_quiet_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("output valid right after reset");

	// An empty block always has room for input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!m_axis_tvalid) && !m_axis_tvalid && $past(!s_axis_tvalid) |->
		s_axis_tready)
		else $error("input stalled while idle");

endmodule

bind baconian_letter_codec_top blc_checker u_blc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast),
	.m_axis_tuser (m_axis_tuser)
);
